FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/lcs_pkg.sv
// Package with sizes and controller/datapath interface types for the substring matcher.
`timescale 1ns / 1ps
package lcs_pkg;
  localparam int MAX_LEN = 64;
  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  localparam logic ACT_SECOND = 1'b0;
  localparam logic ACT_FIRST  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic row_step;
    logic emit_read;
    logic out_load;
    logic emit_next;
    logic clear;
  } lcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic first_room;
    logic row_done;
    logic emit_last;
    logic slot_free;
  } lcs_stat_t;
endpackage

FILE: rtl/lcs_datapath.sv
// Datapath: string stores, run-length row, best-match tracking and output register.
`timescale 1ns / 1ps
module lcs_datapath (
  input  logic              clk,
  input  logic              rst,
  input  lcs_pkg::lcs_cmd_t cmd,
  output lcs_pkg::lcs_stat_t stat,
  input  logic              in_action,
  input  logic [7:0]        in_symbol,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [31:0]       m_tdata,
  output logic              m_tuser,
  output logic              m_tlast
);
  import lcs_pkg::*;

  logic [7:0]    second_mem [MAX_LEN];
  logic [7:0]    first_mem  [MAX_LEN];
  logic [CW-1:0] run_mem    [MAX_LEN];
  logic [MAX_LEN-1:0] run_valid;

  logic [CW-1:0] second_count;
  logic [CW-1:0] first_count;
  logic [7:0]    cur_char;
  logic [CW-1:0] rj;
  logic [AW-1:0] pj;
  logic          pend;
  logic [CW-1:0] diag;
  logic [7:0]    sc_q;
  logic [CW-1:0] rr_q;
  logic          rv_q;
  logic [CW-1:0] best_len;
  logic [CW-1:0] best_ef;
  logic [CW-1:0] best_es;
  logic          ovf;
  logic [CW-1:0] emit_k;
  logic [7:0]    fc_q;

  logic          row_more;
  logic [CW-1:0] above;
  logic [CW-1:0] fresh;
  logic [CW-1:0] emit_pos;
  logic          best_zero;
  logic          out_last;

  assign row_more  = rj < second_count;
  assign above     = rv_q ? rr_q : '0;
  assign fresh     = (sc_q == cur_char) ? CW'(diag + CW'(1)) : '0;
  assign emit_pos  = CW'(CW'(best_ef - best_len) + emit_k);
  assign best_zero = best_len == '0;
  assign out_last  = best_zero || (CW'(emit_k + CW'(1)) == best_len);

  assign stat.first_room = first_count < CW'(MAX_LEN);
  assign stat.row_done   = !pend && !row_more;
  assign stat.emit_last  = out_last;
  assign stat.slot_free  = !m_tvalid || m_tready;

  // String stores, one port each, and the run-length row, read and written in the same cycle.
  always_ff @(posedge clk) begin
    if (cmd.accept && in_action == ACT_SECOND && second_count < CW'(MAX_LEN)) begin
      second_mem[second_count[AW-1:0]] <= in_symbol;
    end
    if (cmd.accept && in_action == ACT_FIRST && first_count < CW'(MAX_LEN)) begin
      first_mem[first_count[AW-1:0]] <= in_symbol;
    end
    if (cmd.row_step && row_more) begin
      sc_q <= second_mem[rj[AW-1:0]];
      rr_q <= run_mem[rj[AW-1:0]];
    end
    if (cmd.row_step && pend) begin
      run_mem[pj] <= fresh;
    end
    if (cmd.emit_read) begin
      fc_q <= first_mem[emit_pos[AW-1:0]];
    end
  end

  // Counters, row sweep control and best-match tracking.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      second_count <= '0;
      first_count  <= '0;
      run_valid    <= '0;
      best_len     <= '0;
      best_ef      <= '0;
      best_es      <= '0;
      ovf          <= 1'b0;
      emit_k       <= '0;
      pend         <= 1'b0;
      rj           <= '0;
    end else begin
      if (cmd.accept) begin
        if (in_action == ACT_SECOND) begin
          if (second_count < CW'(MAX_LEN)) begin
            second_count <= CW'(second_count + CW'(1));
          end else begin
            ovf <= 1'b1;
          end
        end else begin
          if (first_count < CW'(MAX_LEN)) begin
            first_count <= CW'(first_count + CW'(1));
            cur_char    <= in_symbol;
            rj          <= '0;
            pend        <= 1'b0;
            diag        <= '0;
          end else begin
            ovf <= 1'b1;
          end
        end
      end
      if (cmd.row_step) begin
        if (row_more) begin
          rv_q <= run_valid[rj[AW-1:0]];
          pj   <= rj[AW-1:0];
          rj   <= CW'(rj + CW'(1));
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
        if (pend) begin
          run_valid[pj] <= 1'b1;
          diag          <= above;
          if (fresh > best_len) begin
            best_len <= fresh;
            best_ef  <= first_count;
            best_es  <= CW'(CW'(pj) + CW'(1));
          end
        end
      end
      if (cmd.emit_next) begin
        emit_k <= CW'(emit_k + CW'(1));
      end
    end
  end

  // Output register: holds a result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.out_load) begin
      m_tdata <= {2'b00, ovf, (best_zero ? 8'd0 : fc_q), 7'(best_es), 7'(best_ef),
                  7'(best_len)};
      m_tuser <= !best_zero;
      m_tlast <= out_last;
    end
  end
endmodule

FILE: rtl/lcs_ctrl.sv
// Controller state machine: input acceptance, row sweep and result emission.
`timescale 1ns / 1ps
module lcs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               s_tuser,
  input  logic               s_tlast,
  input  lcs_pkg::lcs_stat_t stat,
  output lcs_pkg::lcs_cmd_t  cmd
);
  import lcs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_ROW     = 4'b0010,
    ST_EMIT_RD = 4'b0100,
    ST_EMIT_OUT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   fin, fin_next;
  logic   take;

  assign s_tready = state == ST_IDLE;
  assign take     = s_tvalid && s_tready;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    fin_next   = fin;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (take) begin
          cmd.accept = 1'b1;
          fin_next   = s_tlast;
          if (s_tuser == ACT_FIRST && stat.first_room) begin
            state_next = ST_ROW;
          end else if (s_tlast) begin
            state_next = ST_EMIT_RD;
          end
        end
      end
      ST_ROW: begin
        cmd.row_step = 1'b1;
        if (stat.row_done) begin
          state_next = fin ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        cmd.emit_read = 1'b1;
        state_next    = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (stat.slot_free) begin
          cmd.out_load = 1'b1;
          if (stat.emit_last) begin
            cmd.clear  = 1'b1;
            fin_next   = 1'b0;
            state_next = ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      fin   <= fin_next;
    end
  end
endmodule

FILE: rtl/longest_common_substring.sv
// Top level of the streaming longest-common-substring matcher.
//
//  channel | dir | fields
//  s_*     | in  | tuser: action; tdata[7:0]: symbol; tlast: final_item
//  m_*     | out | tdata: match_length, end_in_first, end_in_second, out_char,
//          |     |        overflow; tuser: char_valid; tlast: last_result
//
// A second-string character, or a dropped one, only needs the accept. A first-string
// character goes through the accept, one cell read per cycle from the second-string store
// and the run-length row, the last cell write, and a check that the sweep finished. Each
// result then goes through a store read and an output load, which waits while the sink
// stalls. rst is synchronous and clears the counters, best match, flags and control state;
// after the last result of a run the run state is cleared at once.
`timescale 1ns / 1ps
module longest_common_substring (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] symbol
  input  logic        s_tuser,  // [0] action
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // [6:0] match_length, [13:7] end_in_first,
                                // [20:14] end_in_second, [28:21] out_char,
                                // [29] overflow, [31:30] zero
  output logic        m_tuser,  // [0] char_valid
  output logic        m_tlast
);
  import lcs_pkg::*;

  lcs_cmd_t  cmd;
  lcs_stat_t stat;

  lcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .stat     (stat),
    .cmd      (cmd)
  );

  lcs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_action (s_tuser),
    .in_symbol (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );
endmodule

FILE: rtl/lcs_checker.sv
// Port-level checker for the substring matcher, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tuser,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);
  logic       out_xfer;
  logic       in_wait;
  logic [9:0] in_bus;
  assign out_xfer = m_tvalid && m_tready;
  assign in_wait  = s_tvalid && !s_tready;
  assign in_bus   = {s_tlast, s_tuser, s_tdata};

  // A waiting input item stays offered and unchanged.
  `ASSERT_NXT(a_in_hold, clk, rst, in_wait, s_tvalid && $stable(in_bus))
  // A stalled result stays offered.
  `ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  // An empty result is always the only one of its run.
  `ASSERT_IMP(a_empty_last, clk, rst, out_xfer && !m_tuser, m_tlast && m_tdata[6:0] == 7'd0)
  // A character result carries a nonzero length.
  `ASSERT_IMP(a_len_nz, clk, rst, out_xfer && m_tuser, m_tdata[6:0] != 7'd0)
  // The match end lies no earlier than its length in the first string.
  `ASSERT_IMP(a_end_pos, clk, rst, out_xfer && m_tuser, m_tdata[13:7] >= m_tdata[6:0])
endmodule

bind longest_common_substring lcs_checker u_lcs_checker (.*);
